[hdl/hri_pkg.sv]
package hri_pkg;

  // Sizes that follow from the grid and the loop caps
  localparam int MAX_SIDE        = 256;
  localparam int STORE_DEPTH     = 65536;
  localparam int BISECT_STEPS    = 100;
  localparam int MAX_MARCH_STEPS = 1024;
  localparam int CNT_MAX = (MAX_MARCH_STEPS > BISECT_STEPS) ? MAX_MARCH_STEPS : BISECT_STEPS;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  // Request modes (tuser on the slave side)
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_HEIGHT = 2'd1;
  localparam logic [1:0] MODE_RAY    = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Result status (tuser on the master side)
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_BELOW   = 2'd2;
  localparam logic [1:0] ST_CAP     = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_GRID_SIDE      = 2'd0;
  localparam logic [1:0] REG_HEIGHT_SCALE   = 2'd1;
  localparam logic [1:0] REG_VERTEX_SPACING = 2'd2;
  localparam logic [1:0] REG_TOLERANCE      = 2'd3;

  typedef enum logic {
    OP_EVAL,
    OP_MUL
  } hri_op_e;

  typedef struct packed {
    logic               start;
    hri_op_e            op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } hri_req_t;

  typedef struct packed {
    logic               done;
    logic               ok;
    logic signed [63:0] res;
  } hri_rsp_t;

  typedef struct packed {
    logic [39:0] w;
    logic [31:0] sp2;
    logic [8:0]  side;
    logic [23:0] scale;
  } hri_cfg_t;

  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } hri_wr_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

[hdl/hri_unit.sv]
module hri_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hri_pkg::hri_req_t req_i,
  input  hri_pkg::hri_cfg_t cfg_i,
  input  hri_pkg::hri_wr_t  wr_i,
  output hri_pkg::hri_rsp_t rsp_o
);
  import hri_pkg::*;

  localparam logic [3:0] U_IDLE   = 4'd0;
  localparam logic [3:0] U_DIVX   = 4'd1;
  localparam logic [3:0] U_SPLX   = 4'd2;
  localparam logic [3:0] U_DIVZ   = 4'd3;
  localparam logic [3:0] U_SPLZ   = 4'd4;
  localparam logic [3:0] U_RD     = 4'd5;
  localparam logic [3:0] U_INTERP = 4'd6;
  localparam logic [3:0] U_MUL    = 4'd7;
  localparam logic [3:0] U_FIN    = 4'd8;

  logic [3:0]         state_q, state_d;
  logic               ok_q, ok_d;
  logic [31:0]        div_rem_q, div_rem_d;
  logic [23:0]        div_sh_q, div_sh_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [39:0]        v2_q, v2_d;
  logic [7:0]         j_q, j_d, i_q, i_d;
  logic [16:0]        fx_q, fx_d, fz_q, fz_d;
  logic [7:0]         corner_q [4];
  logic [7:0]         corner_d [4];
  logic signed [31:0] mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic signed [63:0] prod_q, prod_d;

  logic [7:0]  mem [STORE_DEPTH];
  logic [7:0]  rdata_q;
  logic [15:0] raddr;

  logic signed [63:0] two_w, u2, v2;
  logic               outside;
  logic [32:0]        t;
  logic               ge;
  logic [32:0]        diff;
  logic [7:0]         side_m2, cell_idx;
  logic [16:0]        frac;
  logic [8:0]         row, col;
  logic [17:0]        idx;

  logic [17:0]        sum_f;
  logic               lower;
  logic [7:0]         base;
  logic signed [8:0]  d1, d2;
  logic [16:0]        f1, f2;
  logic signed [26:0] p1, p2;
  logic signed [27:0] acc;

  // Local coordinates, doubled so the terrain center needs no halving
  assign two_w   = {23'b0, cfg_i.w, 1'b0};
  assign u2      = $signed({24'b0, cfg_i.w}) + (req_i.a <<< 1);
  assign v2      = $signed({24'b0, cfg_i.w}) - (req_i.b <<< 1);
  assign outside = (u2 < 0) || (u2 > two_w) || (v2 < 0) || (v2 > two_w);

  // One quotient bit per cycle; quotient is cell * 2^16 + fraction
  assign t    = {div_rem_q, div_sh_q[23]};
  assign ge   = t >= {1'b0, cfg_i.sp2};
  assign diff = t - {1'b0, cfg_i.sp2};

  // Clamp at the far edge: last cell, fraction one
  assign side_m2 = 8'(cfg_i.side - 9'd2);
  always_comb begin
    if (div_sh_q[23:16] > side_m2) begin
      cell_idx = side_m2;
      frac     = 17'h10000;
    end else begin
      cell_idx = div_sh_q[23:16];
      frac     = {1'b0, div_sh_q[15:0]};
    end
  end

  // Corner order A, B, C, D
  assign row   = {1'b0, i_q} + {8'b0, cnt_q[1]};
  assign col   = {1'b0, j_q} + {8'b0, cnt_q[0]};
  assign idx   = {9'b0, row} * {9'b0, cfg_i.side} + {9'b0, col};
  assign raddr = idx[15:0];

  // Interpolation on raw bytes; scale is applied afterwards
  assign sum_f = {1'b0, fx_q} + {1'b0, fz_q};
  assign lower = sum_f < 18'h10000;
  assign base  = lower ? corner_q[0] : corner_q[3];
  assign d1    = $signed({1'b0, corner_q[1]}) - $signed({1'b0, base});
  assign d2    = $signed({1'b0, corner_q[2]}) - $signed({1'b0, base});
  assign f1    = lower ? fx_q : 17'h10000 - fz_q;
  assign f2    = lower ? fz_q : 17'h10000 - fx_q;
  assign p1    = d1 * $signed({1'b0, f1});
  assign p2    = d2 * $signed({1'b0, f2});
  assign acc   = $signed({4'b0, base, 16'b0}) + {p1[26], p1} + {p2[26], p2};

  always_comb begin
    state_d   = state_q;
    ok_d      = ok_q;
    div_rem_d = div_rem_q;
    div_sh_d  = div_sh_q;
    cnt_d     = cnt_q;
    v2_d      = v2_q;
    j_d       = j_q;
    i_d       = i_q;
    fx_d      = fx_q;
    fz_d      = fz_q;
    corner_d  = corner_q;
    mul_a_d   = mul_a_q;
    mul_b_d   = mul_b_q;
    prod_d    = prod_q;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_MUL) begin
            mul_a_d = req_i.a[31:0];
            mul_b_d = req_i.b[31:0];
            ok_d    = 1'b1;
            state_d = U_MUL;
          end else if (outside) begin
            ok_d    = 1'b0;
            state_d = U_FIN;
          end else begin
            ok_d      = 1'b1;
            div_rem_d = u2[39:8];
            div_sh_d  = {u2[7:0], 16'h0};
            v2_d      = v2[39:0];
            cnt_d     = '0;
            state_d   = U_DIVX;
          end
        end
      end
      U_DIVX, U_DIVZ: begin
        div_rem_d = ge ? diff[31:0] : t[31:0];
        div_sh_d  = {div_sh_q[22:0], ge};
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'd23) begin
          state_d = (state_q == U_DIVX) ? U_SPLX : U_SPLZ;
        end
      end
      U_SPLX: begin
        j_d       = cell_idx;
        fx_d      = frac;
        div_rem_d = v2_q[39:8];
        div_sh_d  = {v2_q[7:0], 16'h0};
        cnt_d     = '0;
        state_d   = U_DIVZ;
      end
      U_SPLZ: begin
        i_d     = cell_idx;
        fz_d    = frac;
        cnt_d   = '0;
        state_d = U_RD;
      end
      U_RD: begin
        // read data is registered, so it lags the address
        if (cnt_q != 5'd0) begin
          corner_d[2'(cnt_q[1:0] - 2'd1)] = rdata_q;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          state_d = U_INTERP;
        end
      end
      U_INTERP: begin
        mul_a_d = {{4{acc[27]}}, acc};
        mul_b_d = {8'b0, cfg_i.scale};
        state_d = U_MUL;
      end
      U_MUL: begin
        prod_d  = mul_a_q * mul_b_q;
        state_d = U_FIN;
      end
      U_FIN: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      ok_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_sh_q  <= div_sh_d;
    v2_q      <= v2_d;
    j_q       <= j_d;
    i_q       <= i_d;
    fx_q      <= fx_d;
    fz_q      <= fz_d;
    corner_q  <= corner_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    prod_q    <= prod_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr];
  end

  assign rsp_o.done = (state_q == U_FIN);
  assign rsp_o.ok   = ok_q;
  assign rsp_o.res  = prod_q >>> 16;

endmodule

[hdl/heightfield_ray_intersect.sv]
// Heightfield ray intersection.
// Requests arrive on the s_axis channel; tuser selects load, height query or
// ray query. A load writes one height byte into the 64K-entry store; it gives
// no result. Mode three is dropped. Height and ray queries give one result
// on m_axis: tuser carries the status, tdata the height or the hit point.
// Configuration goes over the cfg channel, always ready. It must only be
// written while no query is in flight; the block does not enforce this.
// One terrain lookup runs two 24-step restoring divisions (one quotient bit
// per cycle) that split x and z into cell and fraction, four store reads,
// one interpolation and one multiply by the height scale. A ray query takes
// one lookup for the origin, three multiplies for the step vector, then one
// lookup per march step (at most 1024) and per bisection step (at most 100).
// The block takes no new request while a query runs. A finished result sits
// in an output register, so loads are still taken while the receiver stalls;
// a second query finishes and then waits until the first result is taken.
// Reset clears control state and restores the register defaults; the height
// store is not cleared and reads garbage until written.
module heightfield_ray_intersect (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side: tuser = mode[1:0]
  // tdata = sample_index[15:0], sample_value[23:16], origin_x[55:24],
  //         origin_y[87:56], origin_z[119:88], dir_x[151:120],
  //         dir_y[183:152], dir_z[215:184]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [215:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  // master side: tuser = status[1:0]
  // tdata = height_out[31:0], hit_x[63:32], hit_y[95:64], hit_z[127:96]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);
  import hri_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ORIG  = 3'd1;  // origin lookup
  localparam logic [2:0] S_STEP  = 3'd2;  // step vector multiplies
  localparam logic [2:0] S_MARCH = 3'd3;
  localparam logic [2:0] S_MEVAL = 3'd4;
  localparam logic [2:0] S_BIS   = 3'd5;
  localparam logic [2:0] S_BEVAL = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // Configuration registers
  logic [8:0]  side_q;
  logic [23:0] scale_q;
  logic [30:0] spacing_q;
  logic [30:0] tol_q;

  logic [2:0]  state_q, state_d;
  logic [1:0]  mode_q, mode_d;
  logic [1:0]  k_q, k_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [39:0] w_q, w_d;

  logic signed [63:0] p_q [3];
  logic signed [63:0] p_d [3];
  logic signed [63:0] q_q [3];
  logic signed [63:0] q_d [3];
  logic signed [63:0] m_q [3];
  logic signed [63:0] m_d [3];
  logic signed [63:0] st_q [3];
  logic signed [63:0] st_d [3];
  logic [31:0]        dir_q [3];
  logic [31:0]        dir_d [3];
  logic signed [63:0] h_q, h_d;

  // Finished result, waiting for the output register
  logic [1:0]         res_status_q, res_status_d;
  logic signed [31:0] res_height_q, res_height_d;
  logic signed [31:0] res_hit_q [3];
  logic signed [31:0] res_hit_d [3];

  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q;
  logic [31:0]        out_height_q;
  logic [31:0]        out_hit_q [3];
  logic               out_load;

  hri_req_t ureq_q, ureq_d;
  hri_rsp_t ursp;
  hri_cfg_t ucfg;
  hri_wr_t  uwr;

  logic               in_acc;
  logic [8:0]         side_used;
  logic [30:0]        sp_used;
  logic [7:0]         side_m1;
  logic signed [63:0] qn [3];
  logic signed [63:0] mid [3];
  logic signed [63:0] hv, err, err_abs;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Grid side is held to 2..MAX_SIDE, spacing to at least one
  always_comb begin
    if (side_q < 9'd2) begin
      side_used = 9'd2;
    end else if (side_q > 9'(MAX_SIDE)) begin
      side_used = 9'(MAX_SIDE);
    end else begin
      side_used = side_q;
    end
  end
  assign sp_used = (spacing_q == '0) ? 31'd1 : spacing_q;
  assign side_m1 = 8'(side_used - 9'd1);

  assign ucfg.w     = w_q;
  assign ucfg.sp2   = {sp_used, 1'b0};
  assign ucfg.side  = side_used;
  assign ucfg.scale = scale_q;

  // Loads go straight into the store
  assign uwr.en   = in_acc && (s_axis_tuser == MODE_LOAD);
  assign uwr.addr = s_axis_tdata[15:0];
  assign uwr.data = s_axis_tdata[23:16];

  hri_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq_q),
    .cfg_i  (ucfg),
    .wr_i   (uwr),
    .rsp_o  (ursp)
  );

  // Next march point and bisection midpoint (rounded toward minus infinity)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qn[k]  = q_q[k] + st_q[k];
      mid[k] = p_q[k] + ((q_q[k] - p_q[k]) >>> 1);
    end
  end

  // A midpoint off the terrain counts as height zero
  assign hv      = ursp.ok ? ursp.res : 64'sd0;
  assign err     = m_q[1] - hv;
  assign err_abs = (err < 0) ? -err : err;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    w_d          = w_q;
    p_d          = p_q;
    q_d          = q_q;
    m_d          = m_q;
    st_d         = st_q;
    dir_d        = dir_q;
    h_d          = h_q;
    res_status_d = res_status_q;
    res_height_d = res_height_q;
    res_hit_d    = res_hit_q;
    ureq_d       = ureq_q;
    ureq_d.start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser == MODE_HEIGHT || s_axis_tuser == MODE_RAY)) begin
          mode_d   = s_axis_tuser;
          p_d[0]   = sext32(s_axis_tdata[55:24]);
          p_d[1]   = sext32(s_axis_tdata[87:56]);
          p_d[2]   = sext32(s_axis_tdata[119:88]);
          dir_d[0] = s_axis_tdata[151:120];
          dir_d[1] = s_axis_tdata[183:152];
          dir_d[2] = s_axis_tdata[215:184];
          w_d      = {32'b0, side_m1} * {9'b0, sp_used};
          ureq_d.start = 1'b1;
          ureq_d.op    = OP_EVAL;
          ureq_d.a     = sext32(s_axis_tdata[55:24]);
          ureq_d.b     = sext32(s_axis_tdata[119:88]);
          state_d      = S_ORIG;
        end
      end
      S_ORIG: begin
        if (ursp.done) begin
          res_height_d = '0;
          for (int k = 0; k < 3; k++) begin
            res_hit_d[k] = '0;
          end
          if (!ursp.ok) begin
            res_status_d = ST_OUTSIDE;
            state_d      = S_OUT;
          end else if (mode_q == MODE_HEIGHT) begin
            res_status_d = ST_OK;
            res_height_d = sat32(ursp.res);
            state_d      = S_OUT;
          end else if (ursp.res > p_q[1]) begin
            res_status_d = ST_BELOW;
            state_d      = S_OUT;
          end else begin
            h_d          = ursp.res;
            k_d          = '0;
            ureq_d.start = 1'b1;
            ureq_d.op    = OP_MUL;
            ureq_d.a     = sext32(dir_q[0]);
            ureq_d.b     = {33'b0, spacing_q};
            state_d      = S_STEP;
          end
        end
      end
      S_STEP: begin
        // step = dir * spacing, one axis per multiply
        if (ursp.done) begin
          st_d[k_q] = ursp.res;
          if (k_q == 2'd2) begin
            q_d     = p_q;
            cnt_d   = '0;
            state_d = S_MARCH;
          end else begin
            k_d          = k_q + 2'd1;
            ureq_d.start = 1'b1;
            ureq_d.op    = OP_MUL;
            ureq_d.a     = sext32(dir_q[k_q + 2'd1]);
            ureq_d.b     = {33'b0, spacing_q};
          end
        end
      end
      S_MARCH: begin
        if (q_q[1] > h_q) begin
          if (cnt_q == CNT_W'(MAX_MARCH_STEPS)) begin
            res_status_d = ST_CAP;
            res_height_d = '0;
            for (int k = 0; k < 3; k++) begin
              res_hit_d[k] = sat32(q_q[k]);
            end
            state_d = S_OUT;
          end else begin
            p_d          = q_q;
            q_d          = qn;
            cnt_d        = cnt_q + 1'b1;
            ureq_d.start = 1'b1;
            ureq_d.op    = OP_EVAL;
            ureq_d.a     = qn[0];
            ureq_d.b     = qn[2];
            state_d      = S_MEVAL;
          end
        end else begin
          m_d     = p_q;
          cnt_d   = '0;
          state_d = S_BIS;
        end
      end
      S_MEVAL: begin
        if (ursp.done) begin
          if (!ursp.ok) begin
            res_status_d = ST_OUTSIDE;
            res_height_d = '0;
            for (int k = 0; k < 3; k++) begin
              res_hit_d[k] = '0;
            end
            state_d = S_OUT;
          end else begin
            h_d     = ursp.res;
            state_d = S_MARCH;
          end
        end
      end
      S_BIS: begin
        if (cnt_q == CNT_W'(BISECT_STEPS)) begin
          // steps used up: report the last midpoint
          res_status_d = ST_OK;
          res_height_d = '0;
          for (int k = 0; k < 3; k++) begin
            res_hit_d[k] = sat32(m_q[k]);
          end
          state_d = S_OUT;
        end else begin
          m_d          = mid;
          cnt_d        = cnt_q + 1'b1;
          ureq_d.start = 1'b1;
          ureq_d.op    = OP_EVAL;
          ureq_d.a     = mid[0];
          ureq_d.b     = mid[2];
          state_d      = S_BEVAL;
        end
      end
      S_BEVAL: begin
        if (ursp.done) begin
          if (err_abs < $signed({33'b0, tol_q})) begin
            res_status_d = ST_OK;
            res_height_d = '0;
            for (int k = 0; k < 3; k++) begin
              res_hit_d[k] = sat32(m_q[k]);
            end
            state_d = S_OUT;
          end else begin
            if (err > 0) begin
              p_d = m_q;
            end else begin
              q_d = m_q;
            end
            state_d = S_BIS;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: refilled once the previous result has been taken
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      ureq_q       <= '0;
      side_q       <= 9'd256;
      scale_q      <= 24'd65536;
      spacing_q    <= 31'd65536;
      tol_q        <= 31'd655;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      ureq_q       <= ureq_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_GRID_SIDE:      side_q    <= cfg_data_i[8:0];
          REG_HEIGHT_SCALE:   scale_q   <= cfg_data_i[23:0];
          REG_VERTEX_SPACING: spacing_q <= cfg_data_i;
          REG_TOLERANCE:      tol_q     <= cfg_data_i;
          default:            ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    k_q          <= k_d;
    cnt_q        <= cnt_d;
    w_q          <= w_d;
    p_q          <= p_d;
    q_q          <= q_d;
    m_q          <= m_d;
    st_q         <= st_d;
    dir_q        <= dir_d;
    h_q          <= h_d;
    res_status_q <= res_status_d;
    res_height_q <= res_height_d;
    res_hit_q    <= res_hit_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_height_q <= res_height_q;
      for (int k = 0; k < 3; k++) begin
        out_hit_q[k] <= res_hit_q[k];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_hit_q[2], out_hit_q[1], out_hit_q[0], out_height_q};

endmodule

[tb/sv/tb.sv]
module tb;
  import hri_pkg::*;

  localparam int LIMIT_CYCLES = 40_000_000;
  localparam int RAY_BUDGET   = 120;     // terrain lookups allowed per random query
  localparam int CALM_FROM    = 150_000; // no idling on either side in this window
  localparam int CALM_TO      = 230_000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] height;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] hz;
  } answer_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        idx;
    logic [7:0]         val;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic               has_ans;
    answer_t            ans;
  } request_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [30:0]  cfg_data_i = '0;

  heightfield_ray_intersect dut (.*);

  always #2 clk_i = ~clk_i;

  // terrain model state
  logic [7:0]  store [STORE_DEPTH];
  bit          written [STORE_DEPTH];
  logic [8:0]  m_side = 9'd256;
  logic [23:0] m_scale = 24'd65536;
  logic [30:0] m_spacing = 31'd65536;
  logic [30:0] m_tol = 31'd655;
  bit          read_unwritten;
  int          lookups;

  request_t pending [$];
  answer_t  answers [$];
  request_t cur;
  bit       s_took;
  int       cycles;
  int       errors;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint side_in_use();
    if (m_side < 2) return 2;
    if (m_side > MAX_SIDE) return MAX_SIDE;
    return longint'(m_side);
  endfunction

  function automatic longint vertex_height(input longint row, input longint col,
                                           input longint side);
    int idx;
    idx = int'((row * side + col) & 64'hFFFF);
    if (!written[idx]) read_unwritten = 1'b1;
    return longint'(store[idx]) * longint'(m_scale);
  endfunction

  // doubled local coordinate -> cell and Q16.16 fraction; far edge clamps
  function automatic void cell_frac(input longint u2, input longint sp2, input longint side,
                                    output longint cidx, output longint frac);
    longint c;
    c = u2 / sp2;
    if (c > side - 2) begin
      cidx = side - 2;
      frac = 65536;
    end else begin
      cidx = c;
      frac = ((u2 - c * sp2) << 16) / sp2;
    end
  endfunction

  function automatic bit terrain_height(input longint x, input longint z, output longint h);
    longint side, sp, w, u2, v2, i, j, fx, fz, a, b, c, d, acc;
    lookups++;
    h = 0;
    side = side_in_use();
    sp = (m_spacing != 0) ? longint'(m_spacing) : 1;
    w = (side - 1) * sp;
    u2 = w + 2 * x;
    v2 = w - 2 * z;
    if (u2 < 0 || u2 > 2 * w || v2 < 0 || v2 > 2 * w) return 1'b0;
    cell_frac(u2, 2 * sp, side, j, fx);
    cell_frac(v2, 2 * sp, side, i, fz);
    a = vertex_height(i, j, side);
    b = vertex_height(i, j + 1, side);
    c = vertex_height(i + 1, j, side);
    d = vertex_height(i + 1, j + 1, side);
    // upper-left triangle A-B-C or lower-right B-C-D
    if (fx + fz < 65536) acc = a * 65536 + (b - a) * fx + (c - a) * fz;
    else acc = d * 65536 + (b - d) * (65536 - fz) + (c - d) * (65536 - fx);
    h = acc >>> 16;
    return 1'b1;
  endfunction

  function automatic answer_t query_result(input request_t r);
    answer_t res;
    longint p[3], q[3], m[3], st[3], dir[3], h, err;
    int n;
    res = '0;
    p[0] = longint'(r.ox);
    p[1] = longint'(r.oy);
    p[2] = longint'(r.oz);
    dir[0] = longint'(r.dx);
    dir[1] = longint'(r.dy);
    dir[2] = longint'(r.dz);
    if (!terrain_height(p[0], p[2], h)) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    if (r.mode == MODE_HEIGHT) begin
      res.height = 32'(clip32(h));
      return res;
    end
    if (h > p[1]) begin
      res.status = ST_BELOW;
      return res;
    end
    for (int k = 0; k < 3; k++) begin
      st[k] = (dir[k] * longint'(m_spacing)) >>> 16;
      q[k] = p[k];
    end
    // march one spacing at a time until at or under the surface
    n = 0;
    while (q[1] > h) begin
      if (n >= MAX_MARCH_STEPS) begin
        res.status = ST_CAP;
        res.hx = 32'(clip32(q[0]));
        res.hy = 32'(clip32(q[1]));
        res.hz = 32'(clip32(q[2]));
        return res;
      end
      for (int k = 0; k < 3; k++) begin
        p[k] = q[k];
        q[k] += st[k];
      end
      n++;
      if (!terrain_height(q[0], q[2], h)) begin
        res.status = ST_OUTSIDE;
        return res;
      end
    end
    // bisect between last point above and first point below
    for (int k = 0; k < 3; k++) m[k] = p[k];
    for (n = 0; n < BISECT_STEPS; n++) begin
      for (int k = 0; k < 3; k++) m[k] = p[k] + ((q[k] - p[k]) >>> 1);
      if (!terrain_height(m[0], m[2], h)) h = 0;
      err = m[1] - h;
      if ((err < 0 ? -err : err) < longint'(m_tol)) break;
      for (int k = 0; k < 3; k++) begin
        if (err > 0) p[k] = m[k];
        else q[k] = m[k];
      end
    end
    res.hx = 32'(clip32(m[0]));
    res.hy = 32'(clip32(m[1]));
    res.hz = 32'(clip32(m[2]));
    return res;
  endfunction

  // Updates the model and queues the request; queries that would read an
  // unwritten entry or run too long are dropped (returns 0).
  function automatic bit offer(input request_t r, input int budget);
    r.has_ans = 1'b0;
    r.ans = '0;
    if (r.mode == MODE_LOAD) begin
      store[r.idx] = r.val;
      written[r.idx] = 1'b1;
    end else if (r.mode != MODE_NONE) begin
      read_unwritten = 1'b0;
      lookups = 0;
      r.ans = query_result(r);
      if (read_unwritten || lookups > budget) return 1'b0;
      r.has_ans = 1'b1;
    end
    pending.push_back(r);
    return 1'b1;
  endfunction

  function automatic request_t mk(input logic [1:0] mode, input longint x, input longint y,
                                  input longint z, input longint dx, input longint dy,
                                  input longint dz);
    request_t r;
    r = '0;
    r.mode = mode;
    r.ox = 32'(clip32(x));
    r.oy = 32'(clip32(y));
    r.oz = 32'(clip32(z));
    r.dx = 32'(clip32(dx));
    r.dy = 32'(clip32(dy));
    r.dz = 32'(clip32(dz));
    return r;
  endfunction

  function automatic request_t mk_load(input int idx, input int val);
    request_t r;
    r = '0;
    r.mode = MODE_LOAD;
    r.idx = 16'(idx);
    r.val = 8'(val);
    return r;
  endfunction

  // ---------------- stimulus driver ----------------
  function automatic bit calm();
    return cycles >= CALM_FROM && cycles < CALM_TO;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_took) begin
        if (pending.size() > 0 && (calm() || $urandom_range(99) >= 11)) begin
          cur = pending.pop_front();
          s_axis_tdata <= {cur.dz, cur.dy, cur.dx, cur.oz, cur.oy, cur.ox, cur.val, cur.idx};
          s_axis_tuser <= cur.mode;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm() || $urandom_range(99) >= 11;
    end
  end

  // ---------------- monitor and checker ----------------
  always @(posedge clk_i) begin
    answer_t want, got;
    cycles <= cycles + 1;
    s_took <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready && cur.has_ans) answers.push_back(cur.ans);
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96]};
      if (answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: unexpected result status %0d", got.status);
      end else begin
        want = answers.pop_front();
        if (want != got) begin
          errors++;
          if (errors <= 10)
            $display("tb: mismatch exp st=%0d h=%0d hit=(%0d,%0d,%0d)",
                     want.status, want.height, want.hx, want.hy, want.hz,
                     " got st=%0d h=%0d hit=(%0d,%0d,%0d)",
                     got.status, got.height, got.hx, got.hy, got.hz);
        end
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- sequencing ----------------
  task automatic cfg_write(input logic [1:0] index, input logic [30:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_GRID_SIDE:      m_side = value[8:0];
      REG_HEIGHT_SCALE:   m_scale = value[23:0];
      REG_VERTEX_SPACING: m_spacing = value;
      default:            m_tol = value;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every request is taken and every result checked, then let
  // any trailing load settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || answers.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  longint f_r0, f_c0, f_n;  // focus patch: first row, first column, cell count

  function automatic longint pick(input longint first, input longint cnt, input longint sp);
    return (first + $urandom_range(int'(cnt) - 1)) * sp + longint'($urandom_range(int'(sp)));
  endfunction

  task automatic random_items(input int count);
    request_t r;
    longint sp, half, x, z, h, y;
    int kind, done;
    sp = longint'(m_spacing);
    half = ((side_in_use() - 1) * sp) >>> 1;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(99);
      x = pick(f_c0, f_n, sp) - half;
      z = half - pick(f_r0, f_n, sp);
      if (kind < 30) begin
        r = mk_load(0, $urandom_range(255));
        if ($urandom_range(4) == 0) r.idx = 16'($urandom);
        else r.idx = 16'((f_r0 + $urandom_range(int'(f_n))) * side_in_use()
                         + f_c0 + $urandom_range(int'(f_n)));
      end else if (kind < 70) begin
        if ($urandom_range(4) == 0) begin
          x = longint'(signed'(32'($urandom)));
          z = longint'(signed'(32'($urandom)));
        end
        r = mk(MODE_HEIGHT, x, 0, z, 0, 0, 0);
      end else if (kind < 95) begin
        read_unwritten = 1'b0;
        if (!terrain_height(x, z, h)) h = 0;
        case ($urandom_range(6))
          0:       y = h - $urandom_range(3 * 65536);
          1:       y = longint'(signed'(32'($urandom)));
          default: y = h + longint'($urandom_range(3)) * sp + $urandom_range(65535);
        endcase
        case ($urandom_range(6))
          0: r = mk(MODE_RAY, x, y, z, signed'(32'($urandom)), signed'(32'($urandom)),
                    signed'(32'($urandom)));
          1: r = mk(MODE_RAY, x, y, z, $urandom_range(65536) - 32768, $urandom_range(32768),
                    $urandom_range(65536) - 32768);
          default: r = mk(MODE_RAY, x, y, z, $urandom_range(262144) - 131072,
                          -longint'($urandom_range(262144, 16384)),
                          $urandom_range(262144) - 131072);
        endcase
      end else begin
        r = mk(MODE_NONE, x, $urandom, z, $urandom, $urandom, $urandom);
        r.idx = 16'($urandom);
        r.val = 8'($urandom);
      end
      if (offer(r, RAY_BUDGET)) done++;
    end
  endtask

  int t_side  [8] = '{256, 3, 0, 16, 511, 8, 300, 5};
  int t_scale [8] = '{65536, 16777215, 1000, 0, 300000, 12345, 65536, 4000000};
  int t_sp    [8] = '{65536, 4096, 2147483647, 1, 200000, 30000, 70000, 900000};
  int t_tol   [8] = '{655, 0, 2147483647, 100, 655, 5000, 20, 65536};

  initial begin
    longint h0, side;
    bit ok;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 2x2 grid of unit spacing and unit scale
    cfg_write(REG_GRID_SIDE, 31'd2);
    cfg_write(REG_HEIGHT_SCALE, 31'd65536);
    cfg_write(REG_VERTEX_SPACING, 31'd65536);
    cfg_write(REG_TOLERANCE, 31'd655);
    ok = offer(mk_load(0, 10), 0);
    ok = offer(mk_load(1, 255), 0);
    ok = offer(mk_load(2, 0), 0);
    ok = offer(mk_load(3, 40), 0);
    ok = offer(mk_load(65535, 255), 0);   // outside the grid in use
    ok = offer(mk(MODE_NONE, -1, -1, -1, -1, -1, -1), 0);
    ok = offer(mk(MODE_HEIGHT, -32768, 0, 32768, 0, 0, 0), 5000);   // top-left vertex
    ok = offer(mk(MODE_HEIGHT, 32768, 0, -32768, 0, 0, 0), 5000);   // far corner
    ok = offer(mk(MODE_HEIGHT, 32768, 0, 0, 0, 0, 0), 5000);        // far column
    ok = offer(mk(MODE_HEIGHT, 0, 0, 0, 0, 0, 0), 5000);
    ok = offer(mk(MODE_HEIGHT, 1000, 0, -1000, 0, 0, 0), 5000);
    ok = offer(mk(MODE_HEIGHT, -32769, 0, 0, 0, 0, 0), 5000);       // just outside
    ok = offer(mk(MODE_HEIGHT, 0, 0, 32769, 0, 0, 0), 5000);
    ok = offer(mk(MODE_HEIGHT, -64'sd2147483648, 0, 64'sd2147483647, 0, 0, 0), 5000);
    ok = offer(mk(MODE_RAY, 64'sd2147483647, 0, 0, 0, -65536, 0), 5000); // origin outside
    ok = offer(mk(MODE_RAY, 0, -65536, 0, 0, -65536, 0), 5000);          // origin below
    read_unwritten = 1'b0;
    ok = terrain_height(0, 0, h0);
    ok = offer(mk(MODE_RAY, 0, h0, 0, 0, -65536, 0), 5000);              // on the surface
    ok = offer(mk(MODE_RAY, 0, 300 * 65536, 0, 1000, -65536, 500), 5000);
    ok = offer(mk(MODE_RAY, 0, 300 * 65536, 0, 65536, -100, 0), 5000);   // leaves terrain
    ok = offer(mk(MODE_RAY, 0, 300 * 65536, 0, 0, 0, 0), 5000);          // march cap
    ok = offer(mk(MODE_RAY, -32768, 255 * 65536, 32768, -1, 1, -1), 5000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_GRID_SIDE, 31'(t_side[ph]));
      cfg_write(REG_HEIGHT_SCALE, 31'(t_scale[ph]));
      cfg_write(REG_VERTEX_SPACING, 31'(t_sp[ph]));
      cfg_write(REG_TOLERANCE, 31'(t_tol[ph]));
      side = side_in_use();
      // small grids are loaded whole, the full size only on a small patch
      if (side <= 16) begin
        f_r0 = 0;
        f_c0 = 0;
        f_n = side - 1;
      end else begin
        f_r0 = $urandom_range(int'(side) - 7);
        f_c0 = $urandom_range(int'(side) - 7);
        f_n = 5;
      end
      for (longint r = f_r0; r <= f_r0 + f_n; r++)
        for (longint c = f_c0; c <= f_c0 + f_n; c++)
          ok = offer(mk_load(int'(r * side + c), $urandom_range(255)), 0);
      random_items(60);
      drain();  // sender holds off until all results are back
      random_items(60);
      drain();
    end

    repeat (100) @(negedge clk_i);
    if (errors == 0 && answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hdl/hri_pkg.sv
hdl/hri_unit.sv
hdl/heightfield_ray_intersect.sv
tb/sv/tb.sv
